FILE: rtl/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

	// Pattern bytes that steer the checker.
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_QMARK    = 8'h3F;

	localparam int STATUS_W = 4;
	localparam int EPOS_W   = 10;
	localparam int PLEN_W   = 11;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 4'd0,
		ST_EMPTY         = 4'd1,
		ST_TOO_LONG      = 4'd2,
		ST_UNBAL_PAREN   = 4'd3,
		ST_UNBAL_BRACKET = 4'd4,
		ST_UNBAL_BRACE   = 4'd5,
		ST_OPEN_PAREN    = 4'd6,
		ST_OPEN_BRACKET  = 4'd7,
		ST_OPEN_BRACE    = 4'd8,
		ST_NESTED_QUANT  = 4'd9
	} status_t;

	typedef struct packed {
		logic [PLEN_W-1:0] pattern_len;
		logic [EPOS_W-1:0] error_pos;
		status_t           status;
	} verdict_t;

	function automatic logic is_quant(input logic [7:0] c);
		return (c == CH_STAR) || (c == CH_PLUS) || (c == CH_QMARK) || (c == CH_LBRACE);
	endfunction

endpackage

FILE: rtl/psc_tracker.sv
`timescale 1ns / 1ps

// Per-pattern scan state: depths, escape, first underflow, group quantifier
// watch. Verdict is combinational from the state for a terminator byte.
module psc_tracker #(
	parameter int MAX_PATTERN_LEN = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         ch,
	output psc_pkg::verdict_t  verdict
);
	import psc_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 1);
	localparam int POS_W = (MAX_PATTERN_LEN > 2) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATTERN_LEN);

	logic [CNT_W-1:0] paren_q, bracket_q, brace_q, count_q;
	logic             esc_q, grp_open_q, group_quant_q, watch_q, nest_seen_q;
	status_t          syn_code_q;
	logic [POS_W-1:0] syn_pos_q, watch_pos_q, nest_pos_q;

	logic [CNT_W-1:0] paren_d, bracket_d, brace_d, count_d;
	logic             esc_d, grp_open_d, group_quant_d, watch_d, nest_seen_d;
	status_t          syn_code_d;
	logic [POS_W-1:0] syn_pos_d, watch_pos_d, nest_pos_d;
	logic [POS_W-1:0] pos;
	logic             full;

	assign full = (count_q >= MAX_CNT);
	assign pos  = count_q[POS_W-1:0];

	always_comb begin
		paren_d       = paren_q;
		bracket_d     = bracket_q;
		brace_d       = brace_q;
		count_d       = count_q;
		esc_d         = esc_q;
		grp_open_d    = grp_open_q;
		group_quant_d = group_quant_q;
		watch_d       = watch_q;
		watch_pos_d   = watch_pos_q;
		nest_seen_d   = nest_seen_q;
		nest_pos_d    = nest_pos_q;
		syn_code_d    = syn_code_q;
		syn_pos_d     = syn_pos_q;
		if (ch == CH_NUL) begin
			paren_d       = '0;
			bracket_d     = '0;
			brace_d       = '0;
			count_d       = '0;
			esc_d         = 1'b0;
			grp_open_d    = 1'b0;
			group_quant_d = 1'b0;
			watch_d       = 1'b0;
			watch_pos_d   = '0;
			nest_seen_d   = 1'b0;
			nest_pos_d    = '0;
			syn_code_d    = ST_OK;
			syn_pos_d     = '0;
		end else if (!full) begin
			count_d = count_q + 1'b1;
			if (esc_q) begin
				esc_d = 1'b0;
			end else begin
				// byte right after ')' is checked raw, backslash included
				if (watch_q) begin
					watch_d = 1'b0;
					if (is_quant(ch) && group_quant_q && !nest_seen_q) begin
						nest_seen_d = 1'b1;
						nest_pos_d  = watch_pos_q;
					end
				end
				if (ch == CH_BSLASH) begin
					esc_d = 1'b1;
				end else begin
					if (syn_code_q == ST_OK) begin
						case (ch)
							CH_LPAREN: paren_d = paren_q + 1'b1;
							CH_RPAREN: begin
								if (paren_q == '0) begin
									syn_code_d = ST_UNBAL_PAREN;
									syn_pos_d  = pos;
								end else begin
									paren_d = paren_q - 1'b1;
								end
							end
							CH_LBRACKET: bracket_d = bracket_q + 1'b1;
							CH_RBRACKET: begin
								if (bracket_q == '0) begin
									syn_code_d = ST_UNBAL_BRACKET;
									syn_pos_d  = pos;
								end else begin
									bracket_d = bracket_q - 1'b1;
								end
							end
							CH_LBRACE: brace_d = brace_q + 1'b1;
							CH_RBRACE: begin
								if (brace_q == '0) begin
									syn_code_d = ST_UNBAL_BRACE;
									syn_pos_d  = pos;
								end else begin
									brace_d = brace_q - 1'b1;
								end
							end
							default: ;
						endcase
					end
					if (ch == CH_LPAREN) begin
						grp_open_d    = 1'b1;
						group_quant_d = 1'b0;
					end else if (ch == CH_RPAREN) begin
						grp_open_d  = 1'b0;
						watch_d     = 1'b1;
						watch_pos_d = pos;
					end else if (grp_open_q && is_quant(ch)) begin
						group_quant_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paren_q       <= '0;
			bracket_q     <= '0;
			brace_q       <= '0;
			count_q       <= '0;
			esc_q         <= 1'b0;
			grp_open_q    <= 1'b0;
			group_quant_q <= 1'b0;
			watch_q       <= 1'b0;
			watch_pos_q   <= '0;
			nest_seen_q   <= 1'b0;
			nest_pos_q    <= '0;
			syn_code_q    <= ST_OK;
			syn_pos_q     <= '0;
		end else if (step) begin
			paren_q       <= paren_d;
			bracket_q     <= bracket_d;
			brace_q       <= brace_d;
			count_q       <= count_d;
			esc_q         <= esc_d;
			grp_open_q    <= grp_open_d;
			group_quant_q <= group_quant_d;
			watch_q       <= watch_d;
			watch_pos_q   <= watch_pos_d;
			nest_seen_q   <= nest_seen_d;
			nest_pos_q    <= nest_pos_d;
			syn_code_q    <= syn_code_d;
			syn_pos_q     <= syn_pos_d;
		end
	end

	// verdict precedence: empty, too long, first underflow, unclosed, nested
	always_comb begin
		verdict.status      = ST_OK;
		verdict.error_pos   = '0;
		verdict.pattern_len = PLEN_W'(count_q);
		if (count_q == '0) begin
			verdict.status = ST_EMPTY;
		end else if (full) begin
			verdict.status = ST_TOO_LONG;
		end else if (syn_code_q != ST_OK) begin
			verdict.status    = syn_code_q;
			verdict.error_pos = EPOS_W'(syn_pos_q);
		end else if (paren_q != '0) begin
			verdict.status = ST_OPEN_PAREN;
		end else if (bracket_q != '0) begin
			verdict.status = ST_OPEN_BRACKET;
		end else if (brace_q != '0) begin
			verdict.status = ST_OPEN_BRACE;
		end else if (nest_seen_q) begin
			verdict.status    = ST_NESTED_QUANT;
			verdict.error_pos = EPOS_W'(nest_pos_q);
		end
	end

endmodule

FILE: rtl/pattern_syntax_checker.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                        Content
// s_axis    in   s_tvalid s_tready s_tdata[7:0]  one pattern byte per transaction
// m_axis    out  m_tvalid m_tready m_tdata[31:0] one verdict per zero byte
//
// One byte per cycle sustained, except that a zero byte waits in _s1 while a
// held verdict is not taken. A byte is registered (_s1), then the scan state is
// updated; a zero byte also loads the verdict register (_s2).
// arst_n clears all scan state; the block then behaves as at pattern start.
// A stalled verdict only holds back the next zero byte; ordinary bytes keep
// flowing into the scan state while the verdict waits.
module pattern_syntax_checker #(
	parameter int MAX_PATTERN_LEN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [3:0] status, [13:4] error_pos, [24:14] pattern_len
);
	import psc_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       advance;     // s1 byte moves into the scan state this cycle
	logic       is_term_s1;

	logic     valid_s2;
	verdict_t verdict_s2;
	verdict_t verdict;

	assign is_term_s1 = (ch_s1 == CH_NUL);
	// only a terminator needs the verdict register to be free
	assign advance  = valid_s1 && (!is_term_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1 <= s_tdata;
		end
	end

	psc_tracker #(
		.MAX_PATTERN_LEN(MAX_PATTERN_LEN)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (ch_s1),
		.verdict(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && is_term_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_term_s1) begin
			verdict_s2 <= verdict;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, verdict_s2.pattern_len, verdict_s2.error_pos, verdict_s2.status};

	// Position is only reported for underflow and nested-quantifier codes.
	a_epos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (verdict_s2.status == ST_OK || verdict_s2.status == ST_EMPTY ||
		verdict_s2.status == ST_TOO_LONG || verdict_s2.status == ST_OPEN_PAREN ||
		verdict_s2.status == ST_OPEN_BRACKET || verdict_s2.status == ST_OPEN_BRACE)
		|-> verdict_s2.error_pos == '0)
		else $error("error_pos set for a code without position");

	// Empty verdict exactly when no byte preceded the terminator.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((verdict_s2.status == ST_EMPTY) == (verdict_s2.pattern_len == '0)))
		else $error("empty status disagrees with pattern length");

	// A terminator is never taken from s1 while an unaccepted verdict is held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |-> !(advance && is_term_s1))
		else $error("verdict overwritten before transfer");

endmodule

FILE: sim/psc_verdict_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts one verdict per zero byte and compares
// every verdict transaction field by field with the oldest one due.
module psc_verdict_checker #(
	parameter int MAX_LEN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [3:0] status, [13:4] error_pos, [24:14] pattern_len
	output int          fail_count,
	output int          pending
);
	import psc_pkg::*;

	verdict_t verdicts_due[$];

	// scan state of the pattern in flight
	logic [EPOS_W-1:0] paren_d;
	logic [EPOS_W-1:0] bracket_d;
	logic [EPOS_W-1:0] brace_d;
	logic [PLEN_W-1:0] nbytes;
	logic              esc;
	status_t           first_err;  // ST_OK while no underflow seen
	logic [EPOS_W-1:0] first_pos;
	logic              grp_open;
	logic              quant_seen;
	logic              watch;      // previous byte was an unescaped ')'
	logic [EPOS_W-1:0] watch_pos;
	logic              nest_seen;
	logic [EPOS_W-1:0] nest_pos;

	function automatic logic repeats(input logic [7:0] c);
		return c == CH_STAR || c == CH_PLUS || c == CH_QMARK || c == CH_LBRACE;
	endfunction

	task automatic clear_scan();
		paren_d    = '0;
		bracket_d  = '0;
		brace_d    = '0;
		nbytes     = '0;
		esc        = 1'b0;
		first_err  = ST_OK;
		first_pos  = '0;
		grp_open   = 1'b0;
		quant_seen = 1'b0;
		watch      = 1'b0;
		watch_pos  = '0;
		nest_seen  = 1'b0;
		nest_pos   = '0;
	endtask

	task automatic close_one(inout logic [EPOS_W-1:0] depth, input status_t code,
			input logic [EPOS_W-1:0] pos);
		if (depth == '0) begin
			first_err = code;
			first_pos = pos;
		end else begin
			depth = depth - 1'b1;
		end
	endtask

	task automatic scan_byte(input logic [7:0] c);
		verdict_t          v;
		logic [EPOS_W-1:0] pos;
		if (c == CH_NUL) begin
			v.status      = ST_OK;
			v.error_pos   = '0;
			v.pattern_len = nbytes;
			if (nbytes == '0) begin
				v.status = ST_EMPTY;
			end else if (nbytes >= MAX_LEN) begin
				v.status = ST_TOO_LONG;
			end else if (first_err != ST_OK) begin
				v.status    = first_err;
				v.error_pos = first_pos;
			end else if (paren_d != '0) begin
				v.status = ST_OPEN_PAREN;
			end else if (bracket_d != '0) begin
				v.status = ST_OPEN_BRACKET;
			end else if (brace_d != '0) begin
				v.status = ST_OPEN_BRACE;
			end else if (nest_seen) begin
				v.status    = ST_NESTED_QUANT;
				v.error_pos = nest_pos;
			end
			verdicts_due.push_back(v);
			clear_scan();
		end else if (nbytes < MAX_LEN) begin
			pos    = nbytes[EPOS_W-1:0];
			nbytes = nbytes + 1'b1;
			if (esc) begin
				esc = 1'b0;
			end else begin
				// the byte right after ')' is looked at raw, backslash included
				if (watch) begin
					watch = 1'b0;
					if (repeats(c) && quant_seen && !nest_seen) begin
						nest_seen = 1'b1;
						nest_pos  = watch_pos;
					end
				end
				if (c == CH_BSLASH) begin
					esc = 1'b1;
				end else begin
					// depths freeze after the first underflow
					if (first_err == ST_OK) begin
						case (c)
							CH_LPAREN:   paren_d = paren_d + 1'b1;
							CH_RPAREN:   close_one(paren_d, ST_UNBAL_PAREN, pos);
							CH_LBRACKET: bracket_d = bracket_d + 1'b1;
							CH_RBRACKET: close_one(bracket_d, ST_UNBAL_BRACKET, pos);
							CH_LBRACE:   brace_d = brace_d + 1'b1;
							CH_RBRACE:   close_one(brace_d, ST_UNBAL_BRACE, pos);
							default: ;
						endcase
					end
					if (c == CH_LPAREN) begin
						grp_open   = 1'b1;
						quant_seen = 1'b0;
					end else if (c == CH_RPAREN) begin
						grp_open  = 1'b0;
						watch     = 1'b1;
						watch_pos = pos;
					end else if (grp_open && repeats(c)) begin
						quant_seen = 1'b1;
					end
				end
			end
		end
	endtask

	task automatic report(input string msg);
		fail_count++;
		if (fail_count <= 20) begin
			$display("%0t psc_verdict_checker: %s", $time, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			clear_scan();
			verdicts_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = verdict_t'(m_tdata[PLEN_W+EPOS_W+STATUS_W-1:0]);
				if (verdicts_due.size() == 0) begin
					report($sformatf("verdict %h with none due", m_tdata));
				end else begin
					want = verdicts_due.pop_front();
					if (got.status != want.status) begin
						report($sformatf("status %0d, want %0d", got.status, want.status));
					end
					if (got.error_pos != want.error_pos) begin
						report($sformatf("error_pos %0d, want %0d", got.error_pos,
							want.error_pos));
					end
					if (got.pattern_len != want.pattern_len) begin
						report($sformatf("pattern_len %0d, want %0d", got.pattern_len,
							want.pattern_len));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata);
			end
			pending = verdicts_due.size();
		end
	end

endmodule

FILE: sim/tb_pattern_syntax_checker.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the pattern syntax checker. A checker module beside
// the block predicts and compares; this top only feeds pattern bytes, plays
// the verdict receiver and decides pass or fail at the end.
module tb_pattern_syntax_checker;
	import psc_pkg::*;

	localparam int MAX_LEN   = 1024;
	localparam int LIMIT     = 500000;   // cycles, far above the slowest run
	localparam int RAND_BYTES = 470;
	localparam int HOLD_CYCLES = 400;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [31:0] m_tdata;

	int fail_count;
	int pending;
	int cycle_cnt  = 0;
	int rand_bytes = 0;
	bit idle_on    = 1'b1;   // random gaps on both sides
	bit long_hold  = 1'b0;   // asks the receiver for one long hold-off
	bit hold_asked = 1'b0;
	bit rx_started = 1'b0;

	logic [7:0] pat[$];      // pattern under construction, without its terminator

	// Short directed patterns: every verdict code but ST_TOO_LONG, the precedence corners,
	// escapes, a quantifier flag that outlives an inner ')', '{' as a
	// quantifier, and a backslash right before the terminator.
	string dir_pats [18] = '{
		"", "a(b)c", ")", "]", "}", "(", "[", "{",
		"(a*)+", "((a*)b)+", "(a*)\\*", "a\\", "\\(",
		")((", "[(", "(a{2})+", "(a*)+)", "(a*)+(b?)*"
	};

	always #5 clk = ~clk;

	pattern_syntax_checker #(
		.MAX_PATTERN_LEN(MAX_LEN)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	psc_verdict_checker #(
		.MAX_LEN(MAX_LEN)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Verdict receiver. Random stall bursts, plus one long hold-off on request
	// so that verdicts back up and the block stops taking zero bytes.
	initial begin : receiver
		wait (rx_started);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// One byte transaction; entered and left at a falling edge.
	task automatic put_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_pattern();
		foreach (pat[i]) put_byte(pat[i]);
		put_byte(CH_NUL);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) pat.push_back(s[i]);
	endtask

	// '*', '+', '?' or a counted repeat "{n}" / "{n,m}"
	task automatic add_quant();
		case ($urandom_range(0, 4))
			0: pat.push_back(CH_STAR);
			1: pat.push_back(CH_PLUS);
			2: pat.push_back(CH_QMARK);
			default: begin
				pat.push_back(CH_LBRACE);
				pat.push_back(8'(8'h30 + $urandom_range(0, 9)));
				if ($urandom_range(0, 1)) begin
					pat.push_back(8'h2C);
					pat.push_back(8'(8'h30 + $urandom_range(0, 9)));
				end
				pat.push_back(CH_RBRACE);
			end
		endcase
	endtask

	// Mostly well-formed regex with random content; some are broken by a
	// stray opener/closer or a missing close, some are raw byte noise.
	task automatic build_random();
		int depth;
		int ntok;
		int kind;
		logic [7:0] stray;
		pat.delete();
		depth = 0;
		ntok  = $urandom_range(0, 12);
		kind  = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat (ntok) pat.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat (ntok) begin
				case ($urandom_range(0, 11))
					0, 1, 2: pat.push_back(8'(8'h61 + $urandom_range(0, 25)));
					3: pat.push_back(8'($urandom_range(1, 255)));
					4: begin
						pat.push_back(CH_BSLASH);
						pat.push_back(8'($urandom_range(1, 255)));
					end
					5, 6: begin
						pat.push_back(CH_LPAREN);
						depth++;
					end
					7, 8: if (depth > 0) begin
						pat.push_back(CH_RPAREN);
						depth--;
						if ($urandom_range(0, 1)) add_quant();
					end
					9: begin
						pat.push_back(CH_LBRACKET);
						repeat ($urandom_range(1, 3))
							pat.push_back(8'(8'h61 + $urandom_range(0, 25)));
						pat.push_back(CH_RBRACKET);
					end
					default: add_quant();
				endcase
			end
			if (kind <= 2) begin
				// broken: leave groups open and drop in a stray bracket
				case ($urandom_range(0, 5))
					0: stray = CH_RPAREN;
					1: stray = CH_RBRACKET;
					2: stray = CH_RBRACE;
					3: stray = CH_LPAREN;
					4: stray = CH_LBRACKET;
					default: stray = CH_LBRACE;
				endcase
				pat.insert($urandom_range(0, pat.size()), stray);
			end else begin
				repeat (depth) begin
					pat.push_back(CH_RPAREN);
					if ($urandom_range(0, 1)) add_quant();
				end
			end
		end
	endtask

	initial begin : stimulus
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		rx_started = 1'b1;

		foreach (dir_pats[i]) begin
			pat.delete();
			add_str(dir_pats[i]);
			send_pattern();
		end

		while (rand_bytes < RAND_BYTES) begin
			if (rand_bytes >= 150 && !hold_asked) begin
				long_hold  = 1'b1;
				hold_asked = 1'b1;
			end
			if (rand_bytes >= 400) begin
				idle_on = 1'b0;
			end
			build_random();
			rand_bytes += pat.size() + 1;
			send_pattern();
		end
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
